// ===== rtl/shared_memory_dual_stack_macros.svh =====
// Assertion macros for the dual stack checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef SHARED_MEMORY_DUAL_STACK_MACROS_SVH
`define SHARED_MEMORY_DUAL_STACK_MACROS_SVH

// same-cycle implication
`define SMDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smds assertion failed");

// next-cycle implication
`define SMDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smds assertion failed");

`endif

// ===== rtl/smds_pkg.sv =====
// Shared constants, codes and types for the dual stack.
// No dependencies.
package smds_pkg;

    localparam int DEPTH     = 8;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int DATA_W    = 32;
    localparam int DEPTH_O_W = 4;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_PEEK = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_OVER  = 2'd1;
    localparam logic [1:0] STAT_UNDER = 2'd2;

    typedef struct packed {
        logic load;
        logic access;
        logic capture;
    } ctrl_cmd_t;

endpackage

// ===== rtl/smds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module smds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/smds_ctrl.sv =====
// Sequencer for the dual stack: load, memory access, capture, result beat.
// Depends on smds_pkg.
module smds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output smds_pkg::ctrl_cmd_t cmd
);
    import smds_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_ACCESS  = 4'b0010,
        S_CAPTURE = 4'b0100,
        S_RESP    = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS:  state_next = S_CAPTURE;
            S_CAPTURE: state_next = S_RESP;
            S_RESP:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready    = (state_reg == S_IDLE);
    assign m_tvalid    = (state_reg == S_RESP);
    assign cmd.load    = s_tready && s_tvalid;
    assign cmd.access  = (state_reg == S_ACCESS);
    assign cmd.capture = (state_reg == S_CAPTURE);

endmodule

// ===== rtl/smds_dp.sv =====
// Datapath for the dual stack: item registers, stack counts, shared RAM, result.
// Depends on smds_pkg and smds_ram.
module smds_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  smds_pkg::ctrl_cmd_t               cmd,
    input  logic [1:0]                        kind,
    input  logic                              side,
    input  logic signed [smds_pkg::DATA_W-1:0] push_value,
    output logic signed [smds_pkg::DATA_W-1:0] read_value,
    output logic [1:0]                        status,
    output logic [smds_pkg::DEPTH_O_W-1:0]    low_depth,
    output logic [smds_pkg::DEPTH_O_W-1:0]    high_depth
);
    import smds_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    logic [1:0]        kind_reg;
    logic              side_reg;
    logic [DATA_W-1:0] value_reg;
    logic [CNT_W-1:0]  low_cnt_reg;
    logic [CNT_W-1:0]  low_cnt_next;
    logic [CNT_W-1:0]  high_cnt_reg;
    logic [CNT_W-1:0]  high_cnt_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic              rd_ok_reg;
    logic [DATA_W-1:0] read_value_reg;

    logic [CNT_W-1:0]  sel_cnt;
    logic [SUM_W-1:0]  cnt_sum;
    logic              full;
    logic              empty;
    logic              is_push;
    logic              is_read;
    logic              push_ok;
    logic              read_ok;
    logic [CNT_W-1:0]  waddr_full;
    logic [CNT_W-1:0]  raddr_full;
    logic              we;
    logic [DATA_W-1:0] rdata;
    logic [CNT_W+DEPTH_O_W-1:0] low_ext;
    logic [CNT_W+DEPTH_O_W-1:0] high_ext;

    assign sel_cnt = side_reg ? high_cnt_reg : low_cnt_reg;
    assign cnt_sum = {1'b0, low_cnt_reg} + {1'b0, high_cnt_reg};
    assign full    = (cnt_sum >= SUM_W'(DEPTH));
    assign empty   = (sel_cnt == '0);
    assign is_push = (kind_reg == KIND_PUSH);
    assign is_read = (kind_reg == KIND_POP) || (kind_reg == KIND_PEEK);
    assign push_ok = is_push && !full;
    assign read_ok = is_read && !empty;

    // low stack grows up from 0, high stack grows down from the last entry
    assign waddr_full = side_reg ? (CNT_W'(DEPTH - 1) - high_cnt_reg) : low_cnt_reg;
    assign raddr_full = side_reg ? (CNT_W'(DEPTH) - high_cnt_reg)
                                 : (low_cnt_reg - CNT_W'(1));
    assign we = cmd.access && push_ok;

    always_comb
    begin
        priority if (is_push && full)
        begin
            status_next = STAT_OVER;
        end
        else if (is_read && empty)
        begin
            status_next = STAT_UNDER;
        end
        else
        begin
            status_next = STAT_OK;
        end
    end

    always_comb
    begin
        low_cnt_next  = low_cnt_reg;
        high_cnt_next = high_cnt_reg;
        if (cmd.access)
        begin
            if (push_ok)
            begin
                if (side_reg)
                begin
                    high_cnt_next = high_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    low_cnt_next = low_cnt_reg + CNT_W'(1);
                end
            end
            else if (read_ok && (kind_reg == KIND_POP))
            begin
                if (side_reg)
                begin
                    high_cnt_next = high_cnt_reg - CNT_W'(1);
                end
                else
                begin
                    low_cnt_next = low_cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
        end
        else
        begin
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            side_reg  <= side;
            value_reg <= push_value;
        end
        if (cmd.access)
        begin
            status_reg <= status_next;
            rd_ok_reg  <= read_ok;
        end
        if (cmd.capture)
        begin
            read_value_reg <= rd_ok_reg ? rdata : '0;
        end
    end

    smds_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr_full[ADDR_W-1:0]),
        .wdata (value_reg),
        .raddr (raddr_full[ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign low_ext    = {{DEPTH_O_W{1'b0}}, low_cnt_reg};
    assign high_ext   = {{DEPTH_O_W{1'b0}}, high_cnt_reg};
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign low_depth  = low_ext[DEPTH_O_W-1:0];
    assign high_depth = high_ext[DEPTH_O_W-1:0];

endmodule

// ===== rtl/shared_memory_dual_stack.sv =====
// Top level of the dual stack: two stacks sharing one RAM.
// Depends on smds_pkg, smds_ctrl, smds_dp, smds_ram.
//
// Two stacks share DEPTH words: the low stack fills from entry 0 upward, the
// high stack from the last entry downward; a push is dropped with overflow
// status when both together hold DEPTH words, and a pop or peek of an empty
// side returns zero with underflow status. Each input beat gives exactly one
// result beat. An item passes through input load, RAM access and capture of the
// registered RAM read before its result is valid, then waits for m_tready; the
// next input beat is taken in the cycle after the result beat, so no new item
// is accepted until the previous result beat has been taken.
// The depth fields carry the low four bits of each stack count.
module shared_memory_dual_stack (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [2:0]  s_tuser,   // [1:0] kind, [2] side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] read_value, [35:32] low_depth, [39:36] high_depth
    output logic [1:0]  m_tuser    // [1:0] status
);
    import smds_pkg::*;

    ctrl_cmd_t                  cmd;
    logic signed [DATA_W-1:0]   read_value;
    logic [1:0]                 status;
    logic [DEPTH_O_W-1:0]       low_depth;
    logic [DEPTH_O_W-1:0]       high_depth;

    smds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    smds_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (s_tuser[1:0]),
        .side       (s_tuser[2]),
        .push_value (s_tdata),
        .read_value (read_value),
        .status     (status),
        .low_depth  (low_depth),
        .high_depth (high_depth)
    );

    assign m_tdata = {high_depth, low_depth, read_value};
    assign m_tuser = status;

endmodule

// ===== rtl/smds_checker.sv =====
// Port-level checker for the dual stack, bound to the top level.
// Depends on smds_pkg and shared_memory_dual_stack_macros.svh.
`include "shared_memory_dual_stack_macros.svh"

module smds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import smds_pkg::*;

    logic [4:0] depth_sum;
    logic       in_beat;

    assign depth_sum = {1'b0, m_tdata[35:32]} + {1'b0, m_tdata[39:36]};
    assign in_beat   = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);

    `SMDS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `SMDS_ASSERT_NOW(a_one_item, m_tvalid || in_beat, !(m_tvalid && s_tready))
    `SMDS_ASSERT_NOW(a_err_zero, m_tvalid && (m_tuser != STAT_OK), m_tdata[31:0] == 32'd0)
    `SMDS_ASSERT_NOW(a_over_full, m_tvalid && (m_tuser == STAT_OVER), depth_sum == 5'(DEPTH))
    `SMDS_ASSERT_NOW(a_sum_bound, m_tvalid, depth_sum <= 5'(DEPTH))

endmodule

bind shared_memory_dual_stack smds_checker u_smds_checker (.*);

// ===== tb/shared_memory_dual_stack_tb.sv =====
// Self-checking testbench for shared_memory_dual_stack: random and directed push, pop
// and peek beats on both stacks, checked against a predictor of the shared store.
// Depends on smds_pkg and the shared_memory_dual_stack RTL.
module shared_memory_dual_stack_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smds_pkg::*;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 12;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
        logic [3:0]  low_depth;
        logic [3:0]  high_depth;
    } stack_reply_t;

    class dual_stack_scoreboard;
        logic [31:0]  store [DEPTH];
        int unsigned  low_cnt;
        int unsigned  high_cnt;
        stack_reply_t replies [$];
        int           errors;
        int           n_ok;
        int           n_over;
        int           n_under;

        function new();
            low_cnt  = 0;
            high_cnt = 0;
            errors   = 0;
            n_ok     = 0;
            n_over   = 0;
            n_under  = 0;
        endfunction

        function void note_op(logic [1:0] kind, logic side, logic [31:0] value);
            stack_reply_t r;
            int unsigned  cnt;
            int unsigned  idx;
            r   = '0;
            cnt = side ? high_cnt : low_cnt;
            if (kind == KIND_PUSH) begin
                if (low_cnt + high_cnt >= DEPTH) begin
                    r.status = STAT_OVER;
                end
                else if (!side) begin
                    store[low_cnt] = value;
                    low_cnt++;
                end
                else begin
                    store[DEPTH - 1 - high_cnt] = value;
                    high_cnt++;
                end
            end
            else if (kind == KIND_POP || kind == KIND_PEEK) begin
                if (cnt == 0 || cnt > DEPTH) begin
                    r.status = STAT_UNDER;
                end
                else begin
                    idx = side ? (DEPTH - cnt) : (cnt - 1);
                    r.read_value = store[idx];
                    if (kind == KIND_POP) begin
                        if (side)
                            high_cnt--;
                        else
                            low_cnt--;
                    end
                end
            end
            r.low_depth  = low_cnt[3:0];
            r.high_depth = high_cnt[3:0];
            case (r.status)
                STAT_OVER:  n_over++;
                STAT_UNDER: n_under++;
                default:    n_ok++;
            endcase
            replies.push_back(r);
        endfunction

        function void check_beat(logic [39:0] tdata, logic [1:0] tuser);
            stack_reply_t want;
            if (replies.size() == 0) begin
                $display("%0t: result beat with nothing pending, tdata %h tuser %h",
                         $time, tdata, tuser);
                errors++;
                return;
            end
            want = replies.pop_front();
            if (tdata[31:0] !== want.read_value) begin
                $display("%0t: read_value expected %h actual %h",
                         $time, want.read_value, tdata[31:0]);
                errors++;
            end
            if (tuser !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, tuser);
                errors++;
            end
            if (tdata[35:32] !== want.low_depth) begin
                $display("%0t: low_depth expected %0d actual %0d",
                         $time, want.low_depth, tdata[35:32]);
                errors++;
            end
            if (tdata[39:36] !== want.high_depth) begin
                $display("%0t: high_depth expected %0d actual %0d",
                         $time, want.high_depth, tdata[39:36]);
                errors++;
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int ops_sent       = 0;

    dual_stack_scoreboard sb = new();

    shared_memory_dual_stack dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // call at a rising edge; returns at the edge where the beat is taken
    task automatic send_op(input logic [1:0] kind, input logic side, input logic [31:0] value);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {side, kind};
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_op(kind, side, value);
        ops_sent++;
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int n_items);
        int          issued;
        int          seg_len;
        int          push_pct;
        int          low_pct;
        int          r;
        logic [1:0]  kind;
        logic        side;
        logic [31:0] value;
        issued = 0;
        while (issued < n_items)
        begin
            seg_len = $urandom_range(24, 4);
            case ($urandom_range(2))
                0:       push_pct = 15;
                1:       push_pct = 50;
                default: push_pct = 85;
            endcase
            case ($urandom_range(2))
                0:       low_pct = 10;
                1:       low_pct = 50;
                default: low_pct = 90;
            endcase
            for (int i = 0; i < seg_len && issued < n_items; i++)
            begin
                r = $urandom_range(99);
                if (r < push_pct)
                    kind = KIND_PUSH;
                else if (r >= 98)
                    kind = KIND_NONE;
                else if ($urandom_range(2) == 0)
                    kind = KIND_PEEK;
                else
                    kind = KIND_POP;
                side = ($urandom_range(99) >= low_pct);
                case ($urandom_range(7))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7fff_ffff;
                    2:       value = 32'h0000_0000;
                    3:       value = 32'hffff_ffff;
                    default: value = $urandom;
                endcase
                send_op(kind, side, value);
                issued++;
                if (issued == n_items / 2)
                    drain_replies();
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty sides, unused kind, extremes, fill to full, overflow, empty out
        send_op(KIND_POP, 1'b0, 32'h0);
        send_op(KIND_PEEK, 1'b1, 32'h0);
        send_op(KIND_NONE, 1'b0, 32'h1234_5678);
        send_op(KIND_PUSH, 1'b0, 32'h8000_0000);
        send_op(KIND_PUSH, 1'b1, 32'h7fff_ffff);
        send_op(KIND_PEEK, 1'b0, 32'h0);
        send_op(KIND_PEEK, 1'b1, 32'h0);
        for (int i = 0; i < DEPTH - 2; i++)
            send_op(KIND_PUSH, i[0], (i < 2) ? {32{i[0]}} : $urandom);
        send_op(KIND_PUSH, 1'b0, 32'hdead_beef);
        send_op(KIND_PUSH, 1'b1, 32'hffff_ffff);
        send_op(KIND_NONE, 1'b1, 32'h0);
        for (int i = 0; i < DEPTH; i++)
            send_op(KIND_POP, (i < DEPTH / 2), 32'h0);
        send_op(KIND_POP, 1'b0, 32'h0);
        drain_replies();

        send_gap_pct   = 15;
        recv_stall_pct = 50;
        run_random(430);
        drain_replies();

        send_gap_pct   = 50;
        recv_stall_pct = 15;
        run_random(430);
        drain_replies();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_random(430);
        drain_replies();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.replies.size() != 0)
        begin
            $display("%0d expected results never arrived", sb.replies.size());
            sb.errors++;
        end
        $display("%0d operations on both stacks under three idle mixes", ops_sent);
        $display("results: %0d ok, %0d overflow, %0d underflow; %0d mismatches",
                 sb.n_ok, sb.n_over, sb.n_under, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
